// ----- rtl/rhs_pkg.sv -----
// rhs_pkg: shared types, constants and helpers for the rtt histogram block
// no dependencies; used by rhs_ctrl, rhs_dpath and rtt_histogram_stats
`timescale 1ns / 1ps
`default_nettype none

package rhs_pkg;

  // sizing and scaling
  localparam int unsigned BIN_COUNT_DEF = 256;
  localparam int unsigned BIN_WIDTH_NS  = 5000;
  localparam int unsigned US_PER_KEY    = 5;
  localparam int unsigned LIMIT_RESET   = 10000;
  localparam int unsigned KEY_W         = 20;
  localparam int unsigned VALUE_W       = 23;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned RTT_W         = 32;
  localparam int unsigned SLOT_W        = 8;

  // bin key by reciprocal multiply: floor(rtt / 5000) = ((rtt >> 3) * KEY_RECIP) >> 39,
  // exact for every 32 bit rtt since 5000 = 8 * 625
  localparam int unsigned KEY_PRE_SH    = 3;
  localparam int unsigned KEY_POST_SH   = 39;
  localparam int unsigned RECIP_W       = 30;
  localparam logic [RECIP_W-1:0] KEY_RECIP = 30'd879609303;
  localparam int unsigned DIV_IN_W      = RTT_W - KEY_PRE_SH;
  localparam int unsigned PROD_W        = DIV_IN_W + RECIP_W;

  // item modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              timed_out;
    logic [RTT_W-1:0]  rtt_ns;
    logic [SLOT_W-1:0] read_slot;
  } rhs_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]   sent_count;
    logic [CNT_W-1:0]   received_count;
    logic [RTT_W-1:0]   worst_rtt;
    logic               run_done;
    logic [SLOT_W-1:0]  slot_index;
    logic               slot_valid;
    logic [VALUE_W-1:0] slot_value_us;
    logic [CNT_W-1:0]   slot_count;
    logic               table_full;
  } rhs_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic count_tmo;
    logic count_ans;
    logic div_step;
    logic scan_step;
    logic hit_rd;
    logic hit_wr;
    logic miss;
    logic rd_mem;
    logic rd_cap;
    logic out_load;
  } rhs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mode;
    logic timed_out;
    logic finished;
    logic match;
    logic miss;
    logic out_free;
  } rhs_sts_t;

  // saturating increment of a 32 bit counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rhs_ctrl.sv -----
// rhs_ctrl: sequencing state machine of the rtt histogram block
// depends on rhs_pkg; drives rhs_dpath through rhs_cmd_t, reads rhs_sts_t
`timescale 1ns / 1ps
`default_nettype none

module rhs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rhs_pkg::rhs_sts_t sts,
  output rhs_pkg::rhs_cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DISP   = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_HIT_WR = 8'b0001_0000,
    ST_RD_MEM = 8'b0010_0000,
    ST_RD_CAP = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.mode == rhs_pkg::MODE_READ) begin
          state_nxt = ST_RD_MEM;
        end else if (sts.finished) begin
          state_nxt = ST_FIN;
        end else if (sts.timed_out) begin
          cmd.count_tmo = 1'b1;
          state_nxt     = ST_FIN;
        end else begin
          cmd.count_ans = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.match) begin
          cmd.hit_rd = 1'b1;
          state_nxt  = ST_HIT_WR;
        end else if (sts.miss) begin
          cmd.miss  = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_HIT_WR: begin
        cmd.hit_wr = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_RD_MEM: begin
        cmd.rd_mem = 1'b1;
        state_nxt  = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rhs_dpath.sv -----
// rhs_dpath: counters, bin key multiplier, bin memories, scan pipeline and result register
// depends on rhs_pkg; commanded by rhs_ctrl
`timescale 1ns / 1ps
`default_nettype none

module rhs_dpath #(
  parameter int unsigned BIN_COUNT = rhs_pkg::BIN_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rhs_pkg::rhs_in_t              in_item,
  input  wire logic                          cfg_valid,
  input  wire logic [rhs_pkg::CNT_W-1:0]     cfg_ping_limit,
  input  wire rhs_pkg::rhs_cmd_t             cmd,
  output rhs_pkg::rhs_sts_t                  sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rhs_pkg::rhs_out_t                  out_item
);

  localparam int unsigned IDX_W  = $clog2(BIN_COUNT);
  localparam int unsigned FILL_W = IDX_W + 1;

  // item and run state
  rhs_pkg::rhs_in_t                 item_r;
  logic [rhs_pkg::CNT_W-1:0]        limit_r;
  logic [rhs_pkg::CNT_W-1:0]        sent_r;
  logic [rhs_pkg::CNT_W-1:0]        ans_r;
  logic [rhs_pkg::RTT_W-1:0]        worst_r;
  logic                             fin_r;
  logic [FILL_W-1:0]                fill_r;

  // bin key
  logic [rhs_pkg::PROD_W-1:0]       key_prod_r;
  logic [rhs_pkg::KEY_W-1:0]        key;

  // scan pipeline
  logic [FILL_W-1:0]                issue_r;
  logic                             cmp_vld_r;
  logic [IDX_W-1:0]                 cmp_idx_r;
  logic                             issue_go;
  logic [IDX_W-1:0]                 hit_idx_r;

  // memories
  logic [rhs_pkg::KEY_W-1:0]        key_mem [BIN_COUNT];
  logic [rhs_pkg::CNT_W-1:0]        hit_mem [BIN_COUNT];
  logic [rhs_pkg::KEY_W-1:0]        key_q;
  logic [rhs_pkg::CNT_W-1:0]        hit_q;
  logic                             key_re, hit_re;
  logic [IDX_W-1:0]                 key_ra, hit_ra;
  logic                             key_we, hit_we;
  logic [IDX_W-1:0]                 hit_wa;
  logic [rhs_pkg::CNT_W-1:0]        hit_wd;
  logic                             room;

  // read mode addressing
  logic                             rd_in_range;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             rd_used;

  // reported slot
  logic [rhs_pkg::SLOT_W-1:0]       slot_idx_r;
  logic                             slot_vld_r;
  logic [rhs_pkg::KEY_W-1:0]        slot_key_r;
  logic [rhs_pkg::CNT_W-1:0]        slot_cnt_r;
  logic                             full_r;
  logic [rhs_pkg::CNT_W-1:0]        sent_inc;
  logic [rhs_pkg::CNT_W-1:0]        new_cnt;

  // result register
  logic                             out_valid_r;
  rhs_pkg::rhs_out_t                out_r;

  assign sent_inc    = rhs_pkg::sat_inc(sent_r);
  assign room        = fill_r < FILL_W'(BIN_COUNT);
  assign rd_in_range = 32'(item_r.read_slot) < 32'(BIN_COUNT);
  assign rd_addr     = IDX_W'(item_r.read_slot);
  assign rd_used     = rd_in_range && ({1'b0, rd_addr} < fill_r);
  assign key         = key_prod_r[rhs_pkg::KEY_POST_SH +: rhs_pkg::KEY_W];
  assign new_cnt     = rhs_pkg::sat_inc(hit_q);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rhs_pkg::CNT_W'(rhs_pkg::LIMIT_RESET);
    end else if (cfg_valid) begin
      limit_r <= cfg_ping_limit;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
  end

  // run counters and finish flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r  <= '0;
      ans_r   <= '0;
      worst_r <= '0;
      fin_r   <= 1'b0;
    end else if (cmd.count_tmo) begin
      sent_r <= sent_inc;
      fin_r  <= 1'b1;
    end else if (cmd.count_ans) begin
      sent_r <= sent_inc;
      ans_r  <= rhs_pkg::sat_inc(ans_r);
      if (item_r.rtt_ns > worst_r) begin
        worst_r <= item_r.rtt_ns;
      end
      // limit check on the count after this ping
      if (limit_r != '0 && sent_inc == limit_r) begin
        fin_r <= 1'b1;
      end
    end
  end

  // bin key as the top bits of rtt / 8 times the reciprocal of 625
  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      key_prod_r <= rhs_pkg::PROD_W'(item_r.rtt_ns[rhs_pkg::RTT_W-1:rhs_pkg::KEY_PRE_SH])
                  * rhs_pkg::PROD_W'(rhs_pkg::KEY_RECIP);
    end
  end

  // scan issue and compare stages
  assign issue_go = cmd.scan_step && (issue_r < fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.count_ans) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      cmp_vld_r <= issue_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count_ans) begin
      issue_r <= '0;
    end else if (issue_go) begin
      issue_r   <= issue_r + FILL_W'(1);
      cmp_idx_r <= issue_r[IDX_W-1:0];
    end
    if (cmd.hit_rd) begin
      hit_idx_r <= cmp_idx_r;
    end
  end

  // memory port control
  always_comb begin
    key_re = issue_go || cmd.rd_mem;
    key_ra = cmd.rd_mem ? rd_addr : issue_r[IDX_W-1:0];
    hit_re = cmd.hit_rd || cmd.rd_mem;
    hit_ra = cmd.rd_mem ? rd_addr : cmp_idx_r;
    key_we = cmd.miss && room;
    hit_we = key_we || cmd.hit_wr;
    hit_wa = cmd.hit_wr ? hit_idx_r : fill_r[IDX_W-1:0];
    hit_wd = cmd.hit_wr ? new_cnt : rhs_pkg::CNT_W'(1);
  end

  // bin key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[fill_r[IDX_W-1:0]] <= key;
    end
    if (key_re) begin
      key_q <= key_mem[key_ra];
    end
  end

  // bin hit memory
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= hit_wd;
    end
    if (hit_re) begin
      hit_q <= hit_mem[hit_ra];
    end
  end

  // fill count, bins below it are in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (key_we) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  // reported slot fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      slot_idx_r <= '0;
      slot_vld_r <= 1'b0;
      slot_key_r <= '0;
      slot_cnt_r <= '0;
      full_r     <= 1'b0;
    end else if (cmd.rd_cap) begin
      slot_idx_r <= item_r.read_slot;
      slot_vld_r <= rd_used;
      slot_key_r <= rd_used ? key_q : '0;
      slot_cnt_r <= rd_used ? hit_q : '0;
    end else if (cmd.hit_wr) begin
      slot_idx_r <= rhs_pkg::SLOT_W'(hit_idx_r);
      slot_vld_r <= 1'b1;
      slot_key_r <= key;
      slot_cnt_r <= new_cnt;
    end else if (cmd.miss) begin
      if (room) begin
        slot_idx_r <= rhs_pkg::SLOT_W'(fill_r[IDX_W-1:0]);
        slot_vld_r <= 1'b1;
        slot_key_r <= key;
        slot_cnt_r <= rhs_pkg::CNT_W'(1);
      end else begin
        full_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.sent_count     <= sent_r;
      out_r.received_count <= ans_r;
      out_r.worst_rtt      <= worst_r;
      out_r.run_done       <= fin_r;
      out_r.slot_index     <= slot_idx_r;
      out_r.slot_valid     <= slot_vld_r;
      out_r.slot_value_us  <= rhs_pkg::VALUE_W'(slot_key_r)
                            * rhs_pkg::VALUE_W'(rhs_pkg::US_PER_KEY);
      out_r.slot_count     <= slot_cnt_r;
      out_r.table_full     <= full_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // status to the controller
  always_comb begin
    sts.mode      = item_r.mode;
    sts.timed_out = item_r.timed_out;
    sts.finished  = fin_r;
    sts.match     = cmp_vld_r && (key_q == key);
    sts.miss      = !cmp_vld_r && (issue_r == fill_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // a new bin grows the fill count by one
  a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.miss && room) |=> (fill_r == FILL_W'($past(fill_r) + FILL_W'(1))))
    else $error("fill count did not advance on new bin");

  // the fill count never passes the table size
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.miss |-> (fill_r <= FILL_W'(BIN_COUNT)))
    else $error("fill count beyond table size");

  // answered pings never outnumber sent pings
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    ans_r <= sent_r)
    else $error("received count above sent count");

  // a reported used bin has at least one hit and a full table reports no bin
  a_slot_cons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_r.slot_valid || out_r.slot_count != '0)
                     && !(out_r.table_full && out_r.slot_valid)))
    else $error("inconsistent slot report");

endmodule

`default_nettype wire

// ----- rtl/rtt_histogram_stats.sv -----
// rtt_histogram_stats: top level of the round-trip statistics collector
// depends on rhs_pkg, rhs_ctrl and rhs_dpath
//
// usage:
//   in_valid/in_ready/in_item carry one item: a record (ping outcome) or a read
//   of one histogram bin. out_valid/out_ready/out_item return one result per item.
//   cfg_valid/cfg_ping_limit write the ping limit; cfg_ready is always high. the user
//   must write the limit only while no item is in progress; the block does not enforce it.
// sequence from accept to out_valid, with the output register free:
//   read item: bin memory read, then capture, then result load. timeout or record
//   after the run ended: straight to result load. answered record: the bin key is formed
//   by reciprocal multiply, then the used bins are scanned at one per cycle through
//   the key memory read port; a hit writes back the bin count plus one, a miss adds a
//   new bin if there is room, else marks the table full.
//   items are taken one at a time; in_ready is high only while the controller is
//   idle, so the next item can be accepted in the cycle after a result is loaded.
// reset (rst_n low, synchronous): counters and the run flag clear, every bin is
//   free, the ping limit returns to 10000. no clearing pass is needed.
// stall: a result waits in the output register while the next item is accepted
//   and worked on; that item finishes once the register is taken.
`timescale 1ns / 1ps
`default_nettype none

module rtt_histogram_stats #(
  parameter int unsigned BIN_COUNT = rhs_pkg::BIN_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire rhs_pkg::rhs_in_t          in_item,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output rhs_pkg::rhs_out_t              out_item,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rhs_pkg::CNT_W-1:0] cfg_ping_limit
);

  rhs_pkg::rhs_cmd_t cmd;
  rhs_pkg::rhs_sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // sequencing
  rhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // counters, key multiplier, memories and result register
  rhs_dpath #(
    .BIN_COUNT (BIN_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .cfg_valid      (cfg_valid),
    .cfg_ping_limit (cfg_ping_limit),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

endmodule

`default_nettype wire
